@@ hw/rtl/orrl_pkg.sv @@
// ----------------------------------------------------------------------------
// orrl_pkg - shared types and codes of the overwriting record ring log
// Holds the request and response beat structs, the field widths and the
// operation codes used by the ring log.
// ----------------------------------------------------------------------------
package orrl_pkg;

  // Fixed widths of the beat fields.
  localparam int OP_W      = 2;
  localparam int RECORD_W  = 64;
  localparam int OFFSET_W  = 8;
  localparam int DISCARD_W = 16;
  localparam int INDEX_W   = 8;
  localparam int COUNT_W   = 9;
  localparam int TOTAL_W   = 32;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_PEEK   = 2'd1;
  localparam logic [OP_W-1:0] OP_POP    = 2'd2;
  localparam logic [OP_W-1:0] OP_FORMAT = 2'd3;

  // Status codes.
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_PEEK  = 1'b1;

  // Overwrite total saturates here.
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [RECORD_W-1:0]  record_in;
    logic [OFFSET_W-1:0]  peek_offset;
    logic [DISCARD_W-1:0] discard_request;
  } orrl_req_t;

  typedef struct packed {
    logic                 status;
    logic [RECORD_W-1:0]  record_out;
    logic [COUNT_W-1:0]   discarded;
    logic                 overwrote_oldest;
    logic [INDEX_W-1:0]   head_index;
    logic [INDEX_W-1:0]   tail_index;
    logic [COUNT_W-1:0]   fill_count;
    logic [TOTAL_W-1:0]   overwrite_total;
  } orrl_rsp_t;

endpackage

@@ hw/rtl/orrl_ram.sv @@
// ----------------------------------------------------------------------------
// orrl_ram - generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds its
// value until the next read is enabled.
// ----------------------------------------------------------------------------
module orrl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/overwriting_record_ring_log_top.sv @@
// A result beat is registered and becomes valid in the cycle after its request beat is accepted.
// Throughput: one request beat per cycle while the response side takes beats;
// peek data comes from the single registered read port of the record RAM.
// Reset clears head, tail, fill count, overwrite total and the response valid.
// Record RAM contents are not cleared by reset or format and need no sweep.
// ----------------------------------------------------------------------------
// overwriting_record_ring_log_top - fixed-capacity record ring log
// Write, peek, pop and format of a record ring that overwrites its oldest
// record when full. Records live in a synchronous RAM; pointers, count and
// overwrite total live in registers and are reported on every response.
// ----------------------------------------------------------------------------
module overwriting_record_ring_log_top #(
  parameter int CAPACITY    = 256,
  parameter int RECORD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  orrl_pkg::orrl_req_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output orrl_pkg::orrl_rsp_t rsp
);

  localparam int PW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int AMW = (CW > orrl_pkg::OFFSET_W) ? CW : orrl_pkg::OFFSET_W;
  localparam int SW  = AMW + 1;

  // Ring state.
  logic [PW-1:0]                 head;
  logic [PW-1:0]                 tail;
  logic [CW-1:0]                 count;
  logic [orrl_pkg::TOTAL_W-1:0]  total;

  // Response holding register (state fields come straight from the ring state).
  logic                          res_status;
  logic                          res_peek_ok;
  logic [CW-1:0]                 res_discarded;
  logic                          res_overwrote;

  logic                          req_acc;
  logic                          is_write;
  logic                          is_peek;
  logic                          full;
  logic                          peek_bad;
  logic [CW-1:0]                 pop_n;
  logic [AMW-1:0]                amount;
  logic [SW-1:0]                 wsum;
  logic [SW-1:0]                 wrapped;
  logic [PW-1:0]                 moved_tail;
  logic [PW-1:0]                 head_inc;
  logic [PW-1:0]                 tail_inc;
  logic [RECORD_BITS-1:0]        rdata;
  logic [PW-1:0]                 gap;

  // A new beat is taken when the response register is empty or being drained.
  assign req_ready = !rsp_valid || rsp_ready;
  assign req_acc   = req_valid && req_ready;

  assign is_write = (req.operation == orrl_pkg::OP_WRITE);
  assign is_peek  = (req.operation == orrl_pkg::OP_PEEK);
  assign full     = (count == CW'(CAPACITY));
  assign peek_bad = (AMW'(req.peek_offset) >= AMW'(count));

  // Pop size clamped to the stored count.
  always_comb begin
    if (orrl_pkg::DISCARD_W'(count) < req.discard_request) begin
      pop_n = count;
    end else begin
      pop_n = req.discard_request[CW-1:0];
    end
  end

  // Shared wrap adder: tail plus peek offset or pop size. Both stay below
  // twice the capacity when used, so one compare and subtract wraps them.
  assign amount     = is_peek ? AMW'(req.peek_offset) : AMW'(pop_n);
  assign wsum       = SW'(tail) + SW'(amount);
  assign wrapped    = (wsum >= SW'(CAPACITY)) ? (wsum - SW'(CAPACITY)) : wsum;
  assign moved_tail = wrapped[PW-1:0];

  // Single-step pointer advances.
  assign head_inc = (head == PW'(CAPACITY - 1)) ? '0 : (head + PW'(1));
  assign tail_inc = (tail == PW'(CAPACITY - 1)) ? '0 : (tail + PW'(1));

  // Record storage. A write and a read never share a cycle, and a read issued
  // after a write to the same slot sees the new word, so no forwarding is needed.
  orrl_ram #(
    .WIDTH(RECORD_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (req_acc && is_write),
    .waddr(head),
    .wdata(req.record_in[RECORD_BITS-1:0]),
    .re   (req_acc && is_peek),
    .raddr(moved_tail),
    .rdata(rdata)
  );

  // Ring state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      total <= '0;
    end else if (req_acc) begin
      case (req.operation)
        orrl_pkg::OP_WRITE: begin
          head <= head_inc;
          if (full) begin
            tail <= tail_inc;
            if (total != orrl_pkg::TOTAL_MAX) begin
              total <= total + orrl_pkg::TOTAL_W'(1);
            end
          end else begin
            count <= count + CW'(1);
          end
        end
        orrl_pkg::OP_POP: begin
          tail  <= moved_tail;
          count <= count - pop_n;
        end
        orrl_pkg::OP_FORMAT: begin
          head  <= '0;
          tail  <= '0;
          count <= '0;
          total <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_acc) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Per-operation response fields.
  always_ff @(posedge clk) begin
    if (req_acc) begin
      res_status    <= (is_peek && peek_bad) ? orrl_pkg::STATUS_BAD_PEEK
                                             : orrl_pkg::STATUS_OK;
      res_peek_ok   <= is_peek && !peek_bad;
      res_discarded <= (req.operation == orrl_pkg::OP_POP) ? pop_n : '0;
      res_overwrote <= is_write && full;
    end
  end

  // Response beat assembly.
  always_comb begin
    rsp.status           = res_status;
    rsp.record_out       = res_peek_ok ? orrl_pkg::RECORD_W'(rdata) : '0;
    rsp.discarded        = orrl_pkg::COUNT_W'(res_discarded);
    rsp.overwrote_oldest = res_overwrote;
    rsp.head_index       = orrl_pkg::INDEX_W'(head);
    rsp.tail_index       = orrl_pkg::INDEX_W'(tail);
    rsp.fill_count       = orrl_pkg::COUNT_W'(count);
    rsp.overwrite_total  = total;
  end

  // Distance from tail to head, used by the consistency check.
  assign gap = (head >= tail) ? (head - tail) : PW'(SW'(head) + SW'(CAPACITY) - SW'(tail));

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // Head and tail always stay inside the ring.
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (head < PW'(CAPACITY - 1) || head == PW'(CAPACITY - 1)) &&
    (tail < PW'(CAPACITY - 1) || tail == PW'(CAPACITY - 1)))
    else $error("ring pointer out of range");

  // Head sits count slots past the tail, modulo the capacity.
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    full ? (gap == '0) : (CW'(gap) == count))
    else $error("head, tail and count disagree");

  // A write into a full ring reports the overwrite and keeps the count full.
  a_overwrite: assert property (@(posedge clk) disable iff (rst)
    (req_acc && is_write && full) |=> (res_overwrote && full))
    else $error("overwrite of oldest record not reported");

  // A pop never leaves the count larger than before.
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.operation == orrl_pkg::OP_POP) |=>
    (count == $past(count) - res_discarded))
    else $error("pop count mismatch");

endmodule
